FILE: rtl/core/colc_pkg.sv
package colc_pkg;

    // Classification of one operation word
    typedef enum logic [1:0] {
        CLASS_LEGAL   = 2'd0,
        CLASS_ILLEGAL = 2'd1,
        CLASS_LINE_A  = 2'd2,
        CLASS_LINE_F  = 2'd3
    } t_op_class;

    localparam int unsigned WORD_W   = 16;
    localparam int unsigned CLASS_W  = 2;
    localparam int unsigned VECTOR_W = 4;
    localparam int unsigned S_DATA_W = 16;
    localparam int unsigned M_DATA_W = 8;

    localparam logic [VECTOR_W-1:0] VEC_NONE    = 4'd0;
    localparam logic [VECTOR_W-1:0] VEC_ILLEGAL = 4'd4;
    localparam logic [VECTOR_W-1:0] VEC_LINE_A  = 4'd10;
    localparam logic [VECTOR_W-1:0] VEC_LINE_F  = 4'd11;

    // Special words of the miscellaneous line
    localparam logic [WORD_W-1:0] W_ILLEGAL_OP = 16'h4AFC;
    localparam logic [WORD_W-1:0] W_RTE        = 16'h4E73;
    localparam logic [WORD_W-1:0] W_RTS        = 16'h4E75;
    localparam logic [WORD_W-1:0] W_TRAPV      = 16'h4E76;
    localparam logic [WORD_W-1:0] W_RTR        = 16'h4E77;

    // Effective-address categories; m is mode, r is register
    function automatic logic am_valid(input logic [2:0] m, input logic [2:0] r);
        return (m != 3'd7) || (r <= 3'd4);
    endfunction

    function automatic logic am_data(input logic [2:0] m, input logic [2:0] r);
        return (m != 3'd1) && am_valid(m, r);
    endfunction

    function automatic logic am_alt(input logic [2:0] m, input logic [2:0] r);
        return (m != 3'd7) || (r <= 3'd1);
    endfunction

    function automatic logic am_data_alt(input logic [2:0] m, input logic [2:0] r);
        return (m != 3'd1) && am_alt(m, r);
    endfunction

    function automatic logic am_mem_alt(input logic [2:0] m, input logic [2:0] r);
        return (m >= 3'd2) && am_alt(m, r);
    endfunction

    function automatic logic am_ctl(input logic [2:0] m, input logic [2:0] r);
        return (m == 3'd2) || (m == 3'd5) || (m == 3'd6) || ((m == 3'd7) && (r <= 3'd3));
    endfunction

    function automatic logic am_ctl_alt(input logic [2:0] m, input logic [2:0] r);
        return (m == 3'd2) || (m == 3'd5) || (m == 3'd6) || ((m == 3'd7) && (r <= 3'd1));
    endfunction

    // Line 0: bit operations and immediates
    function automatic logic grp_bits_imm(input logic [WORD_W-1:0] w);
        logic [2:0] m;
        logic [2:0] r;
        logic [1:0] sz;
        logic [2:0] sel;
        logic       ok;
        m   = w[5:3];
        r   = w[2:0];
        sz  = w[7:6];
        sel = w[11:9];
        ok  = 1'b0;
        if (w[8]) begin
            if (m == 3'd1) ok = 1'b1;
            else if (sz == 2'd0) ok = am_data(m, r);
            else ok = am_data_alt(m, r);
        end else begin
            case (sel)
                3'd0, 3'd1, 3'd5: begin
                    if ((m == 3'd7) && (r == 3'd4)) ok = (sz <= 2'd1);
                    else ok = (sz != 2'd3) && am_data_alt(m, r);
                end
                3'd2, 3'd3, 3'd6: ok = (sz != 2'd3) && am_data_alt(m, r);
                3'd4: begin
                    if (sz == 2'd0) ok = am_data(m, r) && !((m == 3'd7) && (r == 3'd4));
                    else ok = am_data_alt(m, r);
                end
                default: ok = 1'b0;
            endcase
        end
        return ok;
    endfunction

    // Lines 1..3: moves
    function automatic logic grp_move(input logic [WORD_W-1:0] w);
        logic [2:0] m;
        logic [2:0] r;
        logic [2:0] dm;
        logic [2:0] dr;
        logic       is_byte;
        logic       ok;
        m       = w[5:3];
        r       = w[2:0];
        dm      = w[8:6];
        dr      = w[11:9];
        is_byte = (w[15:12] == 4'h1);
        if (!am_valid(m, r) || (is_byte && (m == 3'd1))) ok = 1'b0;
        else if (dm == 3'd1) ok = !is_byte;
        else ok = am_data_alt(dm, dr);
        return ok;
    endfunction

    // Line 4: miscellaneous
    function automatic logic grp_misc(input logic [WORD_W-1:0] w);
        logic [2:0] m;
        logic [2:0] r;
        logic [1:0] sz;
        logic [2:0] sel;
        logic       ok;
        m   = w[5:3];
        r   = w[2:0];
        sz  = w[7:6];
        sel = w[11:9];
        ok  = 1'b0;
        if (w[8]) begin
            if (sz == 2'd3) ok = am_ctl(m, r);
            else if (sz == 2'd2) ok = am_data(m, r);
            else ok = 1'b0;
        end else begin
            case (sel)
                3'd0, 3'd1, 3'd2, 3'd3: begin
                    if ((sz != 2'd3) || (sel == 3'd0)) ok = am_data_alt(m, r);
                    else if (sel == 3'd1) ok = 1'b0;
                    else ok = am_data(m, r);
                end
                3'd4: begin
                    if (sz == 2'd0) ok = am_data_alt(m, r);
                    else if (m == 3'd0) ok = 1'b1;
                    else if (sz == 2'd1) ok = am_ctl(m, r);
                    else ok = (m == 3'd4) || am_ctl_alt(m, r);
                end
                3'd5: begin
                    if ((sz == 2'd3) && (w == W_ILLEGAL_OP)) ok = 1'b1;
                    else ok = am_data_alt(m, r);
                end
                3'd6: begin
                    if (sz < 2'd2) ok = 1'b0;
                    else ok = (m == 3'd3) || am_ctl(m, r);
                end
                default: begin
                    if (sz == 2'd0) ok = 1'b0;
                    else if (sz == 2'd1) ok = (w <= W_RTE) || (w == W_RTS) ||
                                              (w == W_TRAPV) || (w == W_RTR);
                    else ok = am_ctl(m, r);
                end
            endcase
        end
        return ok;
    endfunction

    // Line 5: quick add/sub, set on condition, decrement and branch
    function automatic logic grp_quick(input logic [WORD_W-1:0] w);
        logic [2:0] m;
        logic [2:0] r;
        logic [1:0] sz;
        logic       ok;
        m  = w[5:3];
        r  = w[2:0];
        sz = w[7:6];
        if (sz == 2'd3) ok = (m == 3'd1) || am_data_alt(m, r);
        else if (m == 3'd1) ok = (sz != 2'd0);
        else ok = am_alt(m, r);
        return ok;
    endfunction

    // Lines 8 and C: or/divide and and/multiply/exchange
    function automatic logic grp_logic(input logic [WORD_W-1:0] w, input logic is_and);
        logic [2:0] m;
        logic [2:0] r;
        logic [2:0] op;
        logic       ok;
        m  = w[5:3];
        r  = w[2:0];
        op = w[8:6];
        if ((op == 3'd3) || (op == 3'd7) || (op < 3'd3)) ok = am_data(m, r);
        else if (m <= 3'd1) begin
            if (op == 3'd4) ok = 1'b1;
            else if (!is_and) ok = 1'b0;
            else if (op == 3'd5) ok = 1'b1;
            else ok = (m == 3'd1);
        end else ok = am_mem_alt(m, r);
        return ok;
    endfunction

    // Lines 9 and D: subtract and add
    function automatic logic grp_arith(input logic [WORD_W-1:0] w);
        logic [2:0] m;
        logic [2:0] r;
        logic [2:0] op;
        logic       ok;
        m  = w[5:3];
        r  = w[2:0];
        op = w[8:6];
        if ((op == 3'd3) || (op == 3'd7)) ok = am_valid(m, r);
        else if (op < 3'd3) ok = am_valid(m, r) && !((op == 3'd0) && (m == 3'd1));
        else if (m <= 3'd1) ok = 1'b1;
        else ok = am_mem_alt(m, r);
        return ok;
    endfunction

    // Line B: compare and exclusive or
    function automatic logic grp_compare(input logic [WORD_W-1:0] w);
        logic [2:0] m;
        logic [2:0] r;
        logic [2:0] op;
        logic       ok;
        m  = w[5:3];
        r  = w[2:0];
        op = w[8:6];
        if ((op == 3'd3) || (op == 3'd7)) ok = am_valid(m, r);
        else if (op < 3'd3) ok = am_valid(m, r) && !((op == 3'd0) && (m == 3'd1));
        else if (m == 3'd1) ok = 1'b1;
        else ok = am_data_alt(m, r);
        return ok;
    endfunction

    // Line E: shifts and rotates
    function automatic logic grp_shift(input logic [WORD_W-1:0] w);
        logic ok;
        if (w[7:6] != 2'd3) ok = 1'b1;
        else if (w[11]) ok = 1'b0;
        else ok = am_mem_alt(w[5:3], w[2:0]);
        return ok;
    endfunction

    function automatic t_op_class classify(input logic [WORD_W-1:0] w);
        logic      ok;
        t_op_class cls;
        ok  = 1'b0;
        cls = CLASS_ILLEGAL;
        case (w[15:12])
            4'h0:             ok = grp_bits_imm(w);
            4'h1, 4'h2, 4'h3: ok = grp_move(w);
            4'h4:             ok = grp_misc(w);
            4'h5:             ok = grp_quick(w);
            4'h6:             ok = 1'b1;
            4'h7:             ok = !w[8];
            4'h8:             ok = grp_logic(w, 1'b0);
            4'h9, 4'hD:       ok = grp_arith(w);
            4'hB:             ok = grp_compare(w);
            4'hC:             ok = grp_logic(w, 1'b1);
            4'hE:             ok = grp_shift(w);
            default:          ok = 1'b0;
        endcase
        if (w[15:12] == 4'hA) cls = CLASS_LINE_A;
        else if (w[15:12] == 4'hF) cls = CLASS_LINE_F;
        else if (ok) cls = CLASS_LEGAL;
        else cls = CLASS_ILLEGAL;
        return cls;
    endfunction

    function automatic logic [VECTOR_W-1:0] vector_of(input t_op_class cls);
        logic [VECTOR_W-1:0] v;
        case (cls)
            CLASS_LEGAL:   v = VEC_NONE;
            CLASS_ILLEGAL: v = VEC_ILLEGAL;
            CLASS_LINE_A:  v = VEC_LINE_A;
            CLASS_LINE_F:  v = VEC_LINE_F;
            default:       v = VEC_ILLEGAL;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/cpu_opcode_legality_classifier_top.sv
// Opcode legality classifier. Each item on the slave stream is one 16-bit
// primary operation word of the base instruction set; each item on the master
// stream is its verdict: legal, illegal, line-A trap or line-F trap, with the
// matching exception vector (0, 4, 10, 11). Later-generation encodings are
// reported illegal. The block holds a word register and a result register
// with the whole decode between them, so it takes one item every cycle while
// the master side keeps up; each word goes through the word register and then
// the result register. The slave side stays ready while a result waits, as
// long as the word register is free or can move into the result register.
// There is no configuration and no state beyond the two pipeline registers.
module cpu_opcode_legality_classifier_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [colc_pkg::S_DATA_W-1:0]      i_s_tdata,   // [15:0] opcode_word
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [colc_pkg::M_DATA_W-1:0]      o_m_tdata    // [1:0] op_class,
                                                            // [5:2] exception_vector,
                                                            // [7:6] zero
);

    logic                                r_in_valid;
    logic [colc_pkg::WORD_W-1:0]         r_word;
    logic                                r_out_valid;
    logic [colc_pkg::CLASS_W-1:0]        r_class;
    logic [colc_pkg::VECTOR_W-1:0]       r_vector;

    logic                                n_in_valid;
    logic                                n_out_valid;
    logic                                w_out_free;
    logic                                w_advance;
    logic                                w_accept;
    colc_pkg::t_op_class                 w_class;

    // The result register frees up when empty or when its item is taken
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_s_tready = !r_in_valid || w_out_free;
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_class = colc_pkg::classify(r_word);

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end
        if (w_advance) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture the word on accept; hold it otherwise
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_word <= i_s_tdata[colc_pkg::WORD_W-1:0];
        end
    end

    // Load the verdict when the word moves forward
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_class  <= w_class;
            r_vector <= colc_pkg::vector_of(w_class);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_vector, r_class};

`ifndef SYNTHESIS
    // A word that moves forward shows up as a result in the next cycle
    a_advance_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("advanced word did not reach the result register");

    // A word that cannot move forward stays put
    a_word_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_out_free) |=> (r_in_valid && $stable(r_word)))
        else $error("stalled word lost or changed");

    // The vector always agrees with the class of a shown result
    a_vector_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_vector == colc_pkg::vector_of(colc_pkg::t_op_class'(r_class))))
        else $error("exception vector does not match class");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_in_valid && !r_out_valid))
        else $error("pipeline not empty after reset");
`endif

endmodule
